@@ design/cvcl_pkg.sv @@
package cvcl_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int REG_W       = 31;

    // register indexes
    localparam int REG_OFFSET     = 0;
    localparam int REG_PROP_GAIN  = 1;
    localparam int REG_INTEG_GAIN = 2;
    localparam int REG_WINDUP     = 3;
    localparam int REG_CUR_LIMIT  = 4;
    localparam int REG_BUS_INV    = 5;
    localparam int REG_MOD_GAIN   = 6;
    localparam int REG_MOD_LIMIT  = 7;
    localparam int REG_COUNT      = 8;

    localparam logic [REG_W-1:0] REG_RESET [REG_COUNT] = '{
        31'd1073741824, 31'd52428, 31'd7340, 31'd2621,
        31'd128816332, 31'd291065, 31'd786432000, 31'd786432000
    };

    localparam int Q30_SHIFT = 30;

    // loop constants held in Q30
    localparam longint K_IL_VO_Q30 = 64'sd7157551294;
    localparam longint K_IL_IO_Q30 = 64'sd557527020;
    localparam longint K_E_IL_Q30  = 64'sd307038793;
    localparam longint K_E_VO_Q30  = 64'sd2046717235;
    localparam longint K_PROP_Q30  = 64'sd4831838208;
    localparam longint K_RL_Q30    = 64'sd322122547;
    localparam logic signed [31:0] TWO_Q30 = 32'sd2147483646;

    localparam logic signed [31:0] DRIVE_MAX = 32'sd4095;
    localparam logic signed [31:0] DRIVE_MIN = -32'sd4096;

    typedef struct packed {
        logic signed [31:0] voltage_reference;
        logic signed [31:0] output_voltage;
        logic signed [31:0] output_current;
        logic signed [31:0] inductor_current;
        logic [30:0]        bus_voltage;
    } t_in_item;

    typedef struct packed {
        logic signed [12:0] drive;
        logic signed [31:0] current_reference;
        logic               current_clamped;
        logic               drive_clamped;
    } t_out_item;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [REG_W-1:0]       value;
    } t_cfg_req;

    // control of the shared arithmetic unit
    typedef struct packed {
        logic mul_en;
        logic shift30;
        logic alu_sub;
    } t_arith_ctl;

endpackage

@@ design/cvcl_if.sv @@
interface cvcl_in_if;
    import cvcl_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface cvcl_out_if;
    import cvcl_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface cvcl_cfg_if;
    import cvcl_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ design/cascaded_voltage_current_loop.sv @@
// One shared 32x32 multiplier and one saturating adder are stepped through 22
// operations, then the clamp stage; a new sample is accepted only once the
// last result has been loaded into the output register.
// A finished result waits in the output register while the next sample runs.
// Reset (synchronous, active low) clears the integrator and windup term,
// loads the register defaults and empties the output register.
module cascaded_voltage_current_loop #(
    parameter int FRACTION_BITS = 19
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cvcl_in_if.sink     i_in,
    cvcl_out_if.source  o_out,
    cvcl_cfg_if.sink    i_cfg
);
    import cvcl_pkg::*;

    localparam int QS = Q30_SHIFT - FRACTION_BITS;
    localparam logic signed [31:0] K_IL_VO = 32'(K_IL_VO_Q30 >>> QS);
    localparam logic signed [31:0] K_IL_IO = 32'(K_IL_IO_Q30 >>> QS);
    localparam logic signed [31:0] K_E_IL  = 32'(K_E_IL_Q30 >>> QS);
    localparam logic signed [31:0] K_E_VO  = 32'(K_E_VO_Q30 >>> QS);
    localparam logic signed [31:0] K_PROP  = 32'(K_PROP_Q30 >>> QS);
    localparam logic signed [31:0] K_RL    = 32'(K_RL_Q30 >>> QS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef enum logic [4:0] {
        S_VO, S_IO, S_IL, S_ERR, S_NR, S_Y1, S_Y2, S_PI, S_P4, S_IRAW, S_CLAMP,
        S_DLT, S_IERR, S_WC, S_P5, S_T, S_P8, S_E, S_M_MUL, S_M_CAP, S_D_MUL,
        S_D_CAP
    } t_step;

    typedef struct packed {
        logic signed [31:0] value;
        logic               hit;
    } t_clamp;

    function automatic t_clamp clamp_sym(input logic signed [31:0] x,
                                         input logic [REG_W-1:0] lim);
        logic signed [32:0] xs;
        logic signed [32:0] ls;
        t_clamp             c;
        xs = {x[31], x};
        ls = {2'b00, lim};
        c.value = x;
        c.hit   = 1'b0;
        if (xs > ls) begin
            c.value = ls[31:0];
            c.hit   = 1'b1;
        end else if (xs < -ls) begin
            c.value = 32'(-ls);
            c.hit   = 1'b1;
        end
        return c;
    endfunction

    t_state r_state, n_state;
    t_step  r_step, n_step;

    logic [REG_W-1:0] r_regs [REG_COUNT];
    logic signed [31:0] r_integ, r_wc;
    logic               r_out_valid;
    t_out_item          r_out;

    t_in_item           r_in;
    logic signed [31:0] r_vo, r_io, r_il, r_err, r_y, r_inv, r_acc, r_tmp;
    logic signed [31:0] r_iraw, r_iref, r_ierr;
    logic               r_ihit;

    t_arith_ctl         ctl;
    logic signed [31:0] mul_a, mul_b, alu_x, alu_y, ps, alu;
    t_clamp             icl, dcl;
    logic signed [31:0] dshift;
    logic signed [12:0] drive;
    logic               in_acc, out_load;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    cvcl_arith #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_arith (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_mul_a(mul_a),
        .i_mul_b(mul_b),
        .i_alu_x(alu_x),
        .i_alu_y(alu_y),
        .o_ps   (ps),
        .o_alu  (alu)
    );

    // operand selection for each step
    always_comb begin
        ctl   = '0;
        mul_a = '0;
        mul_b = '0;
        alu_x = '0;
        alu_y = '0;
        case (r_step)
            S_VO: begin
                alu_x = r_in.output_voltage;
                alu_y = {1'b0, r_regs[REG_OFFSET]};
                ctl.alu_sub = 1'b1;
            end
            S_IO: begin
                alu_x = r_in.output_current;
                alu_y = {1'b0, r_regs[REG_OFFSET]};
                ctl.alu_sub = 1'b1;
            end
            S_IL: begin
                alu_x = r_in.inductor_current;
                alu_y = {1'b0, r_regs[REG_OFFSET]};
                ctl.alu_sub = 1'b1;
            end
            S_ERR: begin
                alu_x = r_in.voltage_reference;
                alu_y = r_vo;
                ctl.alu_sub = 1'b1;
                ctl.mul_en = 1'b1;
                mul_a = {1'b0, r_in.bus_voltage};
                mul_b = {1'b0, r_regs[REG_BUS_INV]};
            end
            S_NR: begin
                alu_x = TWO_Q30;
                alu_y = ps;
                ctl.alu_sub = 1'b1;
                ctl.mul_en = 1'b1;
                mul_a = {1'b0, r_regs[REG_INTEG_GAIN]};
                mul_b = r_err;
            end
            S_Y1: begin
                alu_x = r_integ;
                alu_y = ps;
                ctl.mul_en = 1'b1;
                ctl.shift30 = 1'b1;
                mul_a = r_inv;
                mul_b = {1'b0, r_regs[REG_BUS_INV]};
            end
            S_Y2: begin
                alu_x = r_y;
                alu_y = r_wc;
                ctl.mul_en = 1'b1;
                mul_a = {1'b0, r_regs[REG_PROP_GAIN]};
                mul_b = r_err;
            end
            S_PI: begin
                alu_x = r_y;
                alu_y = ps;
                ctl.mul_en = 1'b1;
                mul_a = K_IL_IO;
                mul_b = r_io;
            end
            S_P4: begin
                ctl.mul_en = 1'b1;
                mul_a = K_IL_VO;
                mul_b = r_acc;
            end
            S_IRAW: begin
                alu_x = ps;
                alu_y = r_tmp;
            end
            S_DLT: begin
                alu_x = r_iref;
                alu_y = r_iraw;
                ctl.alu_sub = 1'b1;
            end
            S_IERR: begin
                alu_x = r_iref;
                alu_y = r_il;
                ctl.alu_sub = 1'b1;
                ctl.mul_en = 1'b1;
                mul_a = {1'b0, r_regs[REG_WINDUP]};
                mul_b = r_tmp;
            end
            S_WC: begin
                ctl.mul_en = 1'b1;
                mul_a = K_PROP;
                mul_b = r_ierr;
            end
            S_P5: begin
                ctl.mul_en = 1'b1;
                mul_a = K_RL;
                mul_b = r_ierr;
            end
            S_T: begin
                alu_x = ps;
                alu_y = r_tmp;
                ctl.mul_en = 1'b1;
                mul_a = K_E_VO;
                mul_b = r_vo;
            end
            S_P8: begin
                ctl.mul_en = 1'b1;
                mul_a = K_E_IL;
                mul_b = r_acc;
            end
            S_E: begin
                alu_x = ps;
                alu_y = r_tmp;
            end
            S_M_MUL: begin
                ctl.mul_en = 1'b1;
                mul_a = r_acc;
                mul_b = r_inv;
            end
            S_D_MUL: begin
                ctl.mul_en = 1'b1;
                ctl.shift30 = 1'b1;
                mul_a = r_tmp;
                mul_b = {1'b0, r_regs[REG_MOD_GAIN]};
            end
            default: ;
        endcase
    end

    assign icl = clamp_sym(r_iraw, r_regs[REG_CUR_LIMIT]);

    // modulator clamp and integer part of the drive
    always_comb begin
        dcl    = clamp_sym(r_tmp, r_regs[REG_MOD_LIMIT]);
        dshift = dcl.value >>> FRACTION_BITS;
        if (dshift > DRIVE_MAX) begin
            drive = DRIVE_MAX[12:0];
        end else if (dshift < DRIVE_MIN) begin
            drive = DRIVE_MIN[12:0];
        end else begin
            drive = dshift[12:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_RUN;
                    n_step  = S_VO;
                end
            end
            ST_RUN: begin
                if (r_step == S_D_CAP) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = t_step'(r_step + 5'd1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= S_VO;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_wc        <= '0;
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= REG_RESET[k];
            end
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            // drop writes beyond the register list
            if (i_cfg.valid && i_cfg.ready &&
                i_cfg.data.index < CFG_INDEX_W'(REG_COUNT)) begin
                r_regs[i_cfg.data.index[2:0]] <= i_cfg.data.value;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // commit loop state once the windup term is known
            if (r_state == ST_RUN && r_step == S_WC) begin
                r_wc    <= ps;
                r_integ <= r_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in.data;
        end
        if (r_state == ST_RUN) begin
            case (r_step)
                S_VO:    r_vo   <= alu;
                S_IO:    r_io   <= alu;
                S_IL:    r_il   <= alu;
                S_ERR:   r_err  <= alu;
                S_NR:    r_inv  <= alu;
                S_Y1:    r_y    <= alu;
                S_Y2: begin
                    r_y   <= alu;
                    r_inv <= ps;
                end
                S_PI:    r_acc  <= alu;
                S_P4:    r_tmp  <= ps;
                S_IRAW:  r_iraw <= alu;
                S_CLAMP: begin
                    r_iref <= icl.value;
                    r_ihit <= icl.hit;
                end
                S_DLT:   r_tmp  <= alu;
                S_IERR:  r_ierr <= alu;
                S_P5:    r_tmp  <= ps;
                S_T:     r_acc  <= alu;
                S_P8:    r_tmp  <= ps;
                S_E:     r_acc  <= alu;
                S_M_CAP: r_tmp  <= ps;
                S_D_CAP: r_tmp  <= ps;
                default: ;
            endcase
        end
        if (out_load) begin
            r_out.drive             <= drive;
            r_out.current_reference <= r_iref;
            r_out.current_clamped   <= r_ihit;
            r_out.drive_clamped     <= dcl.hit;
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_RUN) && (r_step == S_VO))
        else $error("accepted request did not start the sequence");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_in.ready)
        else $error("input ready while a request is in progress");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid && (r_state == ST_IDLE))
        else $error("finished result not loaded into the output register");

endmodule

@@ design/cvcl_arith.sv @@
module cvcl_arith #(
    parameter int FRACTION_BITS = 19
) (
    input  logic                  i_clk,
    input  cvcl_pkg::t_arith_ctl  i_ctl,
    input  logic signed [31:0]    i_mul_a,
    input  logic signed [31:0]    i_mul_b,
    input  logic signed [31:0]    i_alu_x,
    input  logic signed [31:0]    i_alu_y,
    output logic signed [31:0]    o_ps,
    output logic signed [31:0]    o_alu
);
    import cvcl_pkg::*;

    logic signed [63:0] r_prod;
    logic               r_shift30;
    logic signed [63:0] shifted;
    logic signed [32:0] sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod    <= 64'(i_mul_a) * 64'(i_mul_b);
            r_shift30 <= i_ctl.shift30;
        end
    end

    // floor shift of the held product, then saturate to 32 bits
    always_comb begin
        shifted = r_shift30 ? (r_prod >>> Q30_SHIFT) : (r_prod >>> FRACTION_BITS);
        if (shifted[63:31] != {33{shifted[31]}}) begin
            o_ps = shifted[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            o_ps = shifted[31:0];
        end
    end

    always_comb begin
        if (i_ctl.alu_sub) begin
            sum = {i_alu_x[31], i_alu_x} - {i_alu_y[31], i_alu_y};
        end else begin
            sum = {i_alu_x[31], i_alu_x} + {i_alu_y[31], i_alu_y};
        end
        if (sum[32] != sum[31]) begin
            o_alu = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            o_alu = sum[31:0];
        end
    end

endmodule

@@ verif/testbench.sv @@
module testbench;
    import cvcl_pkg::*;

    localparam int FRAC          = 19;
    localparam int MAX_WAIT      = 17;
    localparam int SETTLE_CYCLES = 30;
    localparam int TAIL_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASES        = 10;
    localparam int PHASE_SAMPLES = 200;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    localparam int          S_MAX   = 32'sh7fff_ffff;
    localparam int          S_MIN   = 32'sh8000_0000;
    localparam int unsigned BUS_MAX = 32'h7fff_ffff;
    // bus sample that gives an exact Q19 unity inverse when the nominal inverse is 2^19
    localparam int unsigned BUS_UNIT = 32'd1073741822;

    typedef enum logic [1:0] {STEP_SAMPLE, STEP_WRITE, STEP_DRAIN} t_step_kind;

    typedef struct {
        t_step_kind kind;
        t_in_item   sample;
        t_cfg_req   write;
        int         gap;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    cvcl_in_if  in_if();
    cvcl_out_if out_if();
    cvcl_cfg_if cfg_if();

    cascaded_voltage_current_loop #(
        .FRACTION_BITS(FRAC)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // control loop state as the block should hold it
    longint loop_regs [REG_COUNT];
    longint loop_integrator;
    longint loop_windup;

    t_step     pending_q[$];
    t_out_item control_results_q[$];

    bit sample_taken;
    bit write_taken;
    bit result_taken;
    bit rx_calm;
    int sender_wait;
    int gap_of_request;
    int settle_count;
    int rx_stall_left;
    int cycle_count;
    int mismatch_count;

    // stimulus shaping
    int gap_mode;
    int ref_bias;
    int sensor_mid;

    function automatic longint sat32(longint x);
        if (x > I32_MAX) return I32_MAX;
        if (x < I32_MIN) return I32_MIN;
        return x;
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        return sat32(a + b);
    endfunction

    function automatic longint sat_diff(longint a, longint b);
        return sat32(a - b);
    endfunction

    function automatic longint qmul(longint a, longint b, int sh);
        return sat32((a * b) >>> sh);
    endfunction

    function automatic longint q_const(longint q30);
        return q30 >>> (Q30_SHIFT - FRAC);
    endfunction

    function automatic longint clamp_sym(longint x, longint lim, output bit hit);
        hit = 1'b1;
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        hit = 1'b0;
        return x;
    endfunction

    function automatic t_out_item run_control_sample(t_in_item s);
        longint off, vref, vo, io, il, vdc, binv;
        longint err, y, pi_out, iraw, iref, ierr, tv, ev, nr, inv, m, d, dc, drv;
        bit ihit, dhit;
        t_out_item r;
        off  = loop_regs[REG_OFFSET];
        binv = loop_regs[REG_BUS_INV];
        vref = $signed(s.voltage_reference);
        vo   = sat_diff($signed(s.output_voltage), off);
        io   = sat_diff($signed(s.output_current), off);
        il   = sat_diff($signed(s.inductor_current), off);
        vdc  = s.bus_voltage;

        // outer PI, windup term from the previous sample folded in
        err    = sat_diff(vref, vo);
        y      = sat_sum(sat_sum(loop_integrator, qmul(loop_regs[REG_INTEG_GAIN], err, FRAC)),
                         loop_windup);
        pi_out = sat_sum(y, qmul(loop_regs[REG_PROP_GAIN], err, FRAC));
        iraw   = sat_sum(qmul(q_const(K_IL_VO_Q30), pi_out, FRAC),
                         qmul(q_const(K_IL_IO_Q30), io, FRAC));
        iref   = clamp_sym(iraw, loop_regs[REG_CUR_LIMIT], ihit);
        loop_windup     = qmul(loop_regs[REG_WINDUP], sat_diff(iref, iraw), FRAC);
        loop_integrator = y;

        // inner proportional loop with voltage feedforward
        ierr = sat_diff(iref, il);
        tv   = sat_sum(qmul(q_const(K_PROP_Q30), ierr, FRAC), qmul(q_const(K_RL_Q30), ierr, FRAC));
        ev   = sat_sum(qmul(q_const(K_E_IL_Q30), tv, FRAC), qmul(q_const(K_E_VO_Q30), vo, FRAC));

        nr  = sat_diff(TWO_Q30, qmul(vdc, binv, FRAC));
        inv = qmul(nr, binv, Q30_SHIFT);
        m   = qmul(ev, inv, FRAC);
        d   = qmul(m, loop_regs[REG_MOD_GAIN], Q30_SHIFT);
        dc  = clamp_sym(d, loop_regs[REG_MOD_LIMIT], dhit);

        drv = dc >>> FRAC;
        if (drv > DRIVE_MAX) drv = DRIVE_MAX;
        if (drv < DRIVE_MIN) drv = DRIVE_MIN;

        r.drive             = drv[12:0];
        r.current_reference = iref[31:0];
        r.current_clamped   = ihit;
        r.drive_clamped     = dhit;
        return r;
    endfunction

    function automatic void apply_register_write(t_cfg_req w);
        if (w.index < REG_COUNT) loop_regs[w.index[2:0]] = w.value;
    endfunction

    function automatic void flag_mismatch(string what, longint want_v, longint got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
    endfunction

    function automatic int draw_gap();
        case (gap_mode)
            0: return 0;
            1: return $urandom_range(0, MAX_WAIT);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
        endcase
    endfunction

    function automatic int draw_stall();
        return rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int jitter(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic t_in_item mk_sample(int vref, int vo, int io, int il, int unsigned vdc);
        t_in_item s;
        s.voltage_reference = vref;
        s.output_voltage    = vo;
        s.output_current    = io;
        s.inductor_current  = il;
        s.bus_voltage       = vdc[30:0];
        return s;
    endfunction

    function automatic t_in_item control_sample(bit tidy);
        t_in_item s;
        if (tidy) begin
            s = mk_sample(ref_bias + jitter(1 << 23), sensor_mid + jitter(1 << 24),
                          sensor_mid + jitter(1 << 23), sensor_mid + jitter(1 << 23),
                          $urandom_range(1700000000, BUS_MAX));
        end else begin
            s = mk_sample($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        return s;
    endfunction

    function automatic void queue_sample(t_in_item s);
        t_step st;
        st.kind   = STEP_SAMPLE;
        st.sample = s;
        st.write  = '0;
        st.gap    = draw_gap();
        pending_q.push_back(st);
    endfunction

    function automatic void queue_write(int idx, logic [REG_W-1:0] v);
        t_step st;
        st.kind        = STEP_WRITE;
        st.sample      = '0;
        st.write.index = idx[CFG_INDEX_W-1:0];
        st.write.value = v;
        st.gap         = 0;
        if (idx == REG_OFFSET) sensor_mid = int'({1'b0, v});
        pending_q.push_back(st);
    endfunction

    function automatic void queue_drain();
        t_step st;
        st.kind   = STEP_DRAIN;
        st.sample = '0;
        st.write  = '0;
        st.gap    = 0;
        pending_q.push_back(st);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // request driver: change inputs on the falling edge
    always @(negedge i_clk) begin : feed_requests
        int wait_left;
        t_step head;
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            cfg_if.valid <= 1'b0;
        end else if ((in_if.valid && !sample_taken) || (cfg_if.valid && !write_taken)) begin
            // hold the request until it is taken
        end else begin
            wait_left = (sample_taken || write_taken) ? gap_of_request : sender_wait;
            if (wait_left > 0) begin
                in_if.valid  <= 1'b0;
                cfg_if.valid <= 1'b0;
                sender_wait  <= wait_left - 1;
            end else begin
                sender_wait <= 0;
                if (pending_q.size() == 0) begin
                    in_if.valid  <= 1'b0;
                    cfg_if.valid <= 1'b0;
                end else begin
                    head = pending_q[0];
                    case (head.kind)
                        STEP_SAMPLE: begin
                            in_if.valid    <= 1'b1;
                            in_if.data     <= head.sample;
                            cfg_if.valid   <= 1'b0;
                            gap_of_request <= head.gap;
                            void'(pending_q.pop_front());
                        end
                        STEP_WRITE: begin
                            in_if.valid    <= 1'b0;
                            cfg_if.valid   <= 1'b1;
                            cfg_if.data    <= head.write;
                            gap_of_request <= head.gap;
                            void'(pending_q.pop_front());
                        end
                        default: begin
                            // drain: advance only once every result is back and the loop has settled
                            in_if.valid  <= 1'b0;
                            cfg_if.valid <= 1'b0;
                            if (control_results_q.size() != 0) begin
                                settle_count <= 0;
                            end else if (settle_count < SETTLE_CYCLES) begin
                                settle_count <= settle_count + 1;
                            end else begin
                                settle_count <= 0;
                                void'(pending_q.pop_front());
                            end
                        end
                    endcase
                end
            end
        end
    end

    // result receiver: stall for a drawn number of cycles after each result
    always @(negedge i_clk) begin : pace_results
        int stall;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            stall = result_taken ? draw_stall() : rx_stall_left;
            if (stall > 0) begin
                out_if.ready  <= 1'b0;
                rx_stall_left <= stall - 1;
            end else begin
                out_if.ready  <= 1'b1;
                rx_stall_left <= 0;
            end
        end
    end

    // sample handshakes on the rising edge, predict and check
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        t_out_item got;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            cycle_count <= cycle_count + 1;
            if (!i_rst_n) begin
                for (int i = 0; i < REG_COUNT; i++) loop_regs[i] = REG_RESET[i];
                loop_integrator = 0;
                loop_windup     = 0;
                sample_taken <= 1'b0;
                write_taken  <= 1'b0;
                result_taken <= 1'b0;
            end else begin
                result_taken <= out_if.valid && out_if.ready;
                if (out_if.valid && out_if.ready) begin
                    got = out_if.data;
                    if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
                    if (control_results_q.size() == 0) begin
                        flag_mismatch("drive of a result with nothing pending", 0, got.drive);
                    end else begin
                        want = control_results_q.pop_front();
                        if (got.drive !== want.drive)
                            flag_mismatch("drive", want.drive, got.drive);
                        if (got.current_reference !== want.current_reference)
                            flag_mismatch("current_reference", want.current_reference,
                                          got.current_reference);
                        if (got.current_clamped !== want.current_clamped)
                            flag_mismatch("current_clamped", want.current_clamped,
                                          got.current_clamped);
                        if (got.drive_clamped !== want.drive_clamped)
                            flag_mismatch("drive_clamped", want.drive_clamped, got.drive_clamped);
                    end
                end
                sample_taken <= in_if.valid && in_if.ready;
                if (in_if.valid && in_if.ready)
                    control_results_q.push_back(run_control_sample(in_if.data));
                write_taken <= cfg_if.valid && cfg_if.ready;
                if (cfg_if.valid && cfg_if.ready) apply_register_write(cfg_if.data);
            end
        end
    end

    initial begin
        logic [REG_W-1:0] v;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
        gap_mode     = 1;
        ref_bias     = 0;
        sensor_mid   = REG_RESET[REG_OFFSET];

        // zero offset, pure feedforward paths, unity bus inverse: hit both clamps exactly
        queue_write(REG_OFFSET, '0);
        queue_write(REG_PROP_GAIN, '0);
        queue_write(REG_INTEG_GAIN, '0);
        queue_write(REG_WINDUP, '0);
        queue_write(REG_CUR_LIMIT, 31'd272229);
        queue_write(REG_BUS_INV, 31'd524288);
        queue_write(REG_MOD_GAIN, 31'd1073741824);
        queue_write(REG_MOD_LIMIT, 31'd999373);
        queue_sample(mk_sample(0, 0, 0, 0, BUS_UNIT));
        queue_sample(mk_sample(0, 524288, 0, 0, BUS_UNIT));
        queue_sample(mk_sample(0, -524288, 0, 0, BUS_UNIT));
        queue_sample(mk_sample(0, 1048576, 0, 0, BUS_UNIT));
        queue_sample(mk_sample(0, 0, 524288, 272229, BUS_UNIT));
        queue_sample(mk_sample(0, 0, -524288, -272229, BUS_UNIT));
        queue_sample(mk_sample(0, 0, 1048576, 0, BUS_UNIT));

        // zero limits: a zero value sits exactly on the limit
        queue_drain();
        queue_write(REG_CUR_LIMIT, '0);
        queue_write(REG_MOD_LIMIT, '0);
        queue_sample(mk_sample(0, 0, 0, 0, BUS_UNIT));
        queue_sample(mk_sample(0, 1, 4, 0, BUS_UNIT));

        // writes past the register list must be dropped, then restore defaults
        queue_drain();
        queue_write(REG_COUNT, '1);
        queue_write((1 << CFG_INDEX_W) - 1, 31'd12345);
        for (int r = 0; r < REG_COUNT; r++) queue_write(r, REG_RESET[r]);
        queue_sample(mk_sample(0, 0, 0, 0, 0));
        queue_sample(mk_sample(S_MAX, S_MAX, S_MAX, S_MAX, BUS_MAX));
        queue_sample(mk_sample(S_MIN, S_MIN, S_MIN, S_MIN, 0));
        queue_sample(mk_sample(S_MAX, sensor_mid, sensor_mid, sensor_mid, 1934000000));
        queue_sample(mk_sample(S_MIN, sensor_mid, sensor_mid, sensor_mid, 1934000000));
        queue_sample(mk_sample(0, S_MIN, S_MAX, S_MIN, BUS_MAX));
        queue_sample(mk_sample(0, S_MAX, S_MIN, S_MAX, 1));

        // every register at full scale: products and drive saturate
        queue_drain();
        for (int r = 0; r < REG_COUNT; r++) queue_write(r, '1);
        queue_sample(mk_sample(S_MAX, S_MIN, S_MAX, S_MIN, BUS_MAX));
        queue_sample(mk_sample(S_MIN, S_MAX, S_MIN, S_MAX, 0));
        queue_sample(mk_sample(1 << 20, 0, 0, 0, 1 << 19));
        queue_sample(mk_sample(0, 0, 0, 0, 0));

        // random phases: defaults, all zero, full scale, then mixed settings
        for (int phase = 0; phase < PHASES; phase++) begin
            queue_drain();
            for (int r = 0; r < REG_COUNT; r++) begin
                case (phase)
                    0: v = REG_RESET[r];
                    1: v = '0;
                    2: v = '1;
                    default: begin
                        case ($urandom_range(0, 3))
                            0: v = REG_W'($urandom);
                            1: v = REG_RESET[r];
                            2: v = REG_W'(REG_RESET[r] * $urandom_range(1, 4));
                            default: v = $urandom_range(0, 1) ? '1 : '0;
                        endcase
                    end
                endcase
                if (phase < 3 || $urandom_range(0, 1) == 1) queue_write(r, v);
            end
            gap_mode = phase % 3;
            // a steady setpoint bias winds the integrator into the current clamp
            ref_bias = jitter(1 << 27);
            repeat (PHASE_SAMPLES) queue_sample(control_sample($urandom_range(0, 99) >= 15));
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_if.valid || cfg_if.valid ||
               control_results_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
